// ===== rtl/core/cidc_pkg.sv =====
// Shared types, sequencer step codes and constant tables for the cascaded
// IIR duty controller. No dependencies; imported by every core module.
package cidc_pkg;

  localparam int StepW = 5;

  // Sequencer steps: one multiply issued per step, then drain and commit
  localparam logic [StepW-1:0] StepVref     = 5'd0;
  localparam logic [StepW-1:0] StepVlpf     = 5'd1;
  localparam logic [StepW-1:0] StepVlpfLast = 5'd5;
  localparam logic [StepW-1:0] StepIlpf     = 5'd6;
  localparam logic [StepW-1:0] StepIlpfLast = 5'd10;
  localparam logic [StepW-1:0] StepVpid     = 5'd11;
  localparam logic [StepW-1:0] StepVpidLast = 5'd19;
  localparam logic [StepW-1:0] StepIpid     = 5'd20;
  localparam logic [StepW-1:0] StepIpidLast = 5'd24;
  localparam logic [StepW-1:0] StepDrain    = 5'd25;
  localparam logic [StepW-1:0] StepCommit   = 5'd26;

  localparam logic RegDutyLimit = 1'b0;
  localparam logic RegSineMode  = 1'b1;

  localparam int DutyW    = 22;
  localparam int LimitW   = 21;
  localparam int DataW    = 32;

  localparam longint CoefScale     = 64'sd100000000;
  localparam longint SineScale     = 64'sd10000;
  localparam int     TablePoints   = 200;
  localparam int     HalfPoints    = 100;
  localparam int     QuarterPoints = 50;

  // Quarter sine wave in units of 1e-4
  localparam int QuarterWave [QuarterPoints+1] = '{
    0, 314, 628, 941, 1253, 1564, 1874, 2181, 2487, 2790, 3090, 3387, 3681,
    3971, 4258, 4540, 4818, 5090, 5358, 5621, 5878, 6129, 6374, 6613, 6845,
    7071, 7290, 7501, 7705, 7902, 8090, 8271, 8443, 8607, 8763, 8910, 9048,
    9178, 9298, 9409, 9511, 9603, 9686, 9759, 9823, 9877, 9921, 9956, 9980,
    9995, 10000};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic valid;
    logic first;
  } mac_ctl_t;

  // Coefficient for each step, units of 1e-8
  function automatic longint coef_raw(int step);
    longint r;
    case (step)
      1, 6:    r = 64'sd22907918;
      2, 7:    r = 64'sd45815837;
      3, 8:    r = 64'sd22907918;
      4, 9:    r = 64'sd28458000;
      5, 10:   r = -64'sd20089676;
      11:      r = -64'sd23473677;
      12:      r = 64'sd33921768;
      13:      r = -64'sd21767410;
      14:      r = 64'sd5233003;
      15:      r = 64'sd397285449;
      16:      r = -64'sd591957015;
      17:      r = 64'sd392055145;
      18:      r = -64'sd97383579;
      19:      r = 64'sd6086318;
      20:      r = -64'sd14512306;
      21:      r = 64'sd6139566;
      22:      r = 64'sd122213691;
      23:      r = -64'sd22213691;
      24:      r = 64'sd8484166;
      default: r = 64'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] coef_q(int step, int frac);
    longint scaled;
    scaled = (coef_raw(step) * (64'sd1 <<< frac)) / CoefScale;
    return scaled[DataW-1:0];
  endfunction

  // Sine point k of the 200-point period, in Q(frac)
  function automatic logic [DataW-1:0] sine_q(int k, int frac);
    int     kk;
    logic   neg;
    longint v;
    kk  = k;
    neg = 1'b0;
    if (kk >= TablePoints) kk = TablePoints - 1;
    if (kk > HalfPoints) begin
      neg = 1'b1;
      kk  = kk - HalfPoints;
    end
    if (kk > QuarterPoints) kk = HalfPoints - kk;
    v = (longint'(QuarterWave[kk]) * (64'sd1 <<< frac)) / SineScale;
    if (neg) v = -v;
    return v[DataW-1:0];
  endfunction

endpackage

// ===== rtl/core/cascaded_iir_duty_controller_unit.sv =====
// Cascaded voltage/current IIR duty controller, top level.
// Depends on cidc_pkg and cidc_mac (shared multiply-accumulate unit).
//
// Input words arrive on s_axis: tuser = 0 marks a control sample, tuser = 1
// a sine phase tick. A tick advances the sine phase and gives no output word.
// A control sample runs 25 multiplies through the single shared 32x32
// multiplier, one per cycle, then a drain and a commit step: the output
// word appears on m_axis as the sequencer leaves its done state, and
// s_axis_tready returns in the same cycle. The next sample is taken only
// then, so no sample is accepted while another is still being processed.
// The multiplier, used once per cycle, sets the sample rate.
// The finished duty sits in an output register; the next sample is taken
// while it waits. If the receiver still holds the previous word when a new
// duty is ready, the sequencer holds in its done state until m_axis_tready.
// Reset clears all filter history, the sine phase and the duty sign, and loads
// duty_limit = 0.9 and sine_mode = 1. Registers must be written through cfg_we_i /
// cfg_idx_i / cfg_data_i only while the block is idle; the block does not enforce it.
module cascaded_iir_duty_controller_unit import cidc_pkg::*; #(
  parameter int FRAC_BITS   = 20,
  parameter int SINE_POINTS = 200
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [95:0]       s_axis_tdata,  // vo_sample, il_sample, reference_amplitude
  input  logic              s_axis_tuser,  // req_type
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,  // duty, zero pad
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [LimitW-1:0] cfg_data_i
);

  localparam int PhaseW = $clog2(SINE_POINTS);
  localparam logic [DataW-1:0] OneQ = DataW'(64'sd1 <<< FRAC_BITS);
  localparam logic [LimitW-1:0] LimitReset = 21'd943718;

  // Constant tables
  logic [DataW-1:0] sine_rom [SINE_POINTS];
  logic [DataW-1:0] coef_rom [2**StepW];

  for (genvar g = 0; g < SINE_POINTS; g++) begin : g_sine
    localparam int K = (g * TablePoints) / SINE_POINTS;
    localparam logic [DataW-1:0] SinePoint = sine_q(K, FRAC_BITS);
    assign sine_rom[g] = SinePoint;
  end

  for (genvar g = 0; g < 2**StepW; g++) begin : g_coef
    localparam logic [DataW-1:0] CoefPoint = coef_q(g, FRAC_BITS);
    assign coef_rom[g] = CoefPoint;
  end

  state_e             state_q, state_d;
  logic [StepW-1:0]   step_q, step_d, issue_q;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic               last_neg_q, last_neg_d;
  logic [LimitW-1:0]  limit_q;
  logic               sine_mode_q;

  logic [DataW-1:0]   vo_q, il_q, amp_q;
  logic [DataW-1:0]   vref_q, vf_q, cf_q, vc_q, ic_q;
  logic [DataW-1:0]   vlx_q [2];
  logic [DataW-1:0]   vly_q [2];
  logic [DataW-1:0]   ilx_q [2];
  logic [DataW-1:0]   ily_q [2];
  logic [DataW-1:0]   vpx_q [4];
  logic [DataW-1:0]   vpy_q [4];
  logic [DataW-1:0]   ipx_q [2];
  logic [DataW-1:0]   ipy_q [2];

  logic               out_valid_q;
  logic [DutyW-1:0]   out_duty_q, res_duty_q, res_duty_d;

  logic               in_acc, out_load, commit;
  logic [DataW-1:0]   err, ie, op_a, op_b, sum;
  mac_ctl_t           mac_in, mac_out;
  logic signed [DataW-1:0] ic_s, lim_s, nlim_s, clamp;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_duty_q};
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
  assign commit        = (state_q == ST_RUN) && (step_q == StepCommit);

  assign err = vref_q - vf_q;
  assign ie  = vc_q - cf_q;

  // Operand select for the shared multiplier
  always_comb begin
    op_b = coef_rom[step_q];
    case (step_q)
      StepVref: begin
        op_a = amp_q;
        op_b = sine_mode_q ? sine_rom[phase_q] : OneQ;
      end
      StepVlpf:     op_a = vo_q;
      5'd2:         op_a = vlx_q[0];
      5'd3:         op_a = vlx_q[1];
      5'd4:         op_a = vly_q[0];
      StepVlpfLast: op_a = vly_q[1];
      StepIlpf:     op_a = il_q;
      5'd7:         op_a = ilx_q[0];
      5'd8:         op_a = ilx_q[1];
      5'd9:         op_a = ily_q[0];
      StepIlpfLast: op_a = ily_q[1];
      StepVpid:     op_a = vpx_q[0];
      5'd12:        op_a = vpx_q[1];
      5'd13:        op_a = vpx_q[2];
      5'd14:        op_a = vpx_q[3];
      5'd15:        op_a = vpy_q[0];
      5'd16:        op_a = vpy_q[1];
      5'd17:        op_a = vpy_q[2];
      5'd18:        op_a = vpy_q[3];
      StepVpidLast: op_a = err;
      StepIpid:     op_a = ipx_q[0];
      5'd21:        op_a = ipx_q[1];
      5'd22:        op_a = ipy_q[0];
      5'd23:        op_a = ipy_q[1];
      StepIpidLast: op_a = ie;
      default:      op_a = '0;
    endcase
  end

  always_comb begin
    mac_in.valid = (state_q == ST_RUN) && (step_q <= StepIpidLast);
    mac_in.first = step_q inside {StepVref, StepVlpf, StepIlpf, StepVpid, StepIpid};
  end

  cidc_mac #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_in),
    .a_i   (op_a),
    .b_i   (op_b),
    .ctl_o (mac_out),
    .sum_o (sum)
  );

  // Symmetric clamp of the current loop output
  always_comb begin
    ic_s   = ic_q;
    lim_s  = {{(DataW-LimitW){1'b0}}, limit_q};
    nlim_s = -lim_s;
    if (ic_s < nlim_s) begin
      clamp = nlim_s;
    end else if (ic_s > lim_s) begin
      clamp = lim_s;
    end else begin
      clamp = ic_s;
    end
    res_duty_d = clamp[DutyW-1:0];
    last_neg_d = commit ? clamp[DataW-1] : last_neg_q;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    phase_d = phase_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            phase_d = (phase_q == PhaseW'(SINE_POINTS - 1)) ? '0 : phase_q + 1'b1;
          end else begin
            state_d = ST_RUN;
            step_d  = StepVref;
          end
        end
      end
      ST_RUN: begin
        if (commit) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= StepVref;
      issue_q     <= StepVref;
      phase_q     <= '0;
      last_neg_q  <= 1'b0;
      limit_q     <= LimitReset;
      sine_mode_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      step_q     <= step_d;
      issue_q    <= step_q;
      phase_q    <= phase_d;
      last_neg_q <= last_neg_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDutyLimit: limit_q     <= cfg_data_i;
          RegSineMode:  sine_mode_q <= cfg_data_i[0];
          default:      ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Filter history: shift in new input and output at commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlx_q <= '{default: '0};
      vly_q <= '{default: '0};
      ilx_q <= '{default: '0};
      ily_q <= '{default: '0};
      vpx_q <= '{default: '0};
      vpy_q <= '{default: '0};
      ipx_q <= '{default: '0};
      ipy_q <= '{default: '0};
    end else if (commit) begin
      vlx_q <= '{vo_q, vlx_q[0]};
      vly_q <= '{vf_q, vly_q[0]};
      ilx_q <= '{il_q, ilx_q[0]};
      ily_q <= '{cf_q, ily_q[0]};
      vpx_q <= '{err, vpx_q[0], vpx_q[1], vpx_q[2]};
      vpy_q <= '{vc_q, vpy_q[0], vpy_q[1], vpy_q[2]};
      ipx_q <= '{ie, ipx_q[0]};
      ipy_q <= '{ic_q, ipy_q[0]};
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tuser) begin
      vo_q  <= s_axis_tdata[31:0];
      il_q  <= last_neg_q ? -s_axis_tdata[63:32] : s_axis_tdata[63:32];
      amp_q <= s_axis_tdata[95:64];
    end
    if (mac_out.valid) begin
      case (issue_q)
        StepVref:     vref_q <= sum;
        StepVlpfLast: vf_q   <= sum;
        StepIlpfLast: cf_q   <= sum;
        StepVpidLast: vc_q   <= sum;
        StepIpidLast: ic_q   <= sum;
        default:      ;
      endcase
    end
    if (commit) res_duty_q <= res_duty_d;
    if (out_load) out_duty_q <= res_duty_q;
  end

  // A tick never starts the sequencer
  a_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> (state_q == ST_IDLE))
    else $error("tick item left the sequencer busy");

  // Delivered duty stays inside the configured limit
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (($signed(out_duty_q) <= lim_s) && ($signed(out_duty_q) >= nlim_s)))
    else $error("duty outside limit");

  // Stored sign follows the duty just loaded
  a_sign_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (last_neg_q == out_duty_q[DutyW-1]))
    else $error("duty sign flag mismatch");

endmodule

// ===== rtl/core/cidc_mac.sv =====
// Shared multiply-accumulate unit: registered 32x32 product, then a
// truncating Q shift and 32-bit wrapping accumulate. Depends on cidc_pkg.
module cidc_mac import cidc_pkg::*; #(
  parameter int FRAC_BITS = 20
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctl_t                ctl_i,
  input  logic signed [DataW-1:0] a_i,
  input  logic signed [DataW-1:0] b_i,
  output mac_ctl_t                ctl_o,
  output logic [DataW-1:0]        sum_o
);

  logic signed [2*DataW-1:0] prod_d, prod_q;
  mac_ctl_t                  ctl_q;
  logic [DataW-1:0]          acc_d, acc_q;

  assign prod_d = a_i * b_i;

  // Floor shift of the product, keep low 32 bits; restart on first term
  assign acc_d = (ctl_q.first ? '0 : acc_q) + prod_q[FRAC_BITS+DataW-1:FRAC_BITS];
  assign sum_o = acc_d;
  assign ctl_o = ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      prod_q <= prod_d;
    end
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== test/cidc_tb_pkg.sv =====
// Request codes shared by the duty controller testbench and its checker.
// No dependencies.
package cidc_tb_pkg;

  localparam bit ReqSample = 1'b0;
  localparam bit ReqTick   = 1'b1;

  // Sample-to-word latency of the block, plus margin for the idle wait
  localparam int SettleCycles = 40;

endpackage

// ===== test/cidc_checker.sv =====
// Scoreboard for the cascaded IIR duty controller: watches the input, output
// and register-write channels, predicts every duty word and compares it.
// Depends on cidc_pkg and cidc_tb_pkg.
module cidc_checker import cidc_pkg::*; import cidc_tb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              s_ready_i,
  input  logic [95:0]       s_data_i,   // vo_sample, il_sample, reference_amplitude
  input  logic              s_user_i,   // req_type
  input  logic              m_valid_i,
  input  logic              m_ready_i,
  input  logic [23:0]       m_data_i,   // duty, zero pad
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [LimitW-1:0] cfg_data_i,
  output int                fail_cnt_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FracBits    = 20;
  localparam int     SinePoints  = 200;
  localparam longint CoefDiv     = 100000000;
  localparam longint SineDiv     = 10000;
  localparam int     LimitReset  = 943718;

  // filter stages
  localparam int StVoltLpf = 0;
  localparam int StCurrLpf = 1;
  localparam int StVoltCtl = 2;
  localparam int StCurrCtl = 3;

  localparam int NumB [4] = '{3, 3, 5, 3};
  localparam int NumA [4] = '{2, 2, 4, 2};

  // coefficients in units of 1e-8
  localparam longint CoefB [4][5] = '{
    '{22907918, 45815837, 22907918, 0, 0},
    '{22907918, 45815837, 22907918, 0, 0},
    '{6086318, -23473677, 33921768, -21767410, 5233003},
    '{8484166, -14512306, 6139566, 0, 0}};
  localparam longint CoefA [4][4] = '{
    '{28458000, -20089676, 0, 0},
    '{28458000, -20089676, 0, 0},
    '{397285449, -591957015, 392055145, -97383579},
    '{122213691, -22213691, 0, 0}};

  // quarter sine wave, units of 1e-4
  localparam int QWave [51] = '{
    0, 314, 628, 941, 1253, 1564, 1874, 2181, 2487, 2790, 3090, 3387, 3681,
    3971, 4258, 4540, 4818, 5090, 5358, 5621, 5878, 6129, 6374, 6613, 6845,
    7071, 7290, 7501, 7705, 7902, 8090, 8271, 8443, 8607, 8763, 8910, 9048,
    9178, 9298, 9409, 9511, 9603, 9686, 9759, 9823, 9877, 9921, 9956, 9980,
    9995, 10000};

  bit [31:0]       x_hist [4][5];
  bit [31:0]       y_hist [4][4];
  bit [7:0]        phase;
  bit              duty_was_neg;
  bit [LimitW-1:0] limit;
  bit              sine_on;
  bit [21:0]       duty_q [$];
  int              fail_cnt;

  function automatic longint to_fixed(longint raw, longint div);
    return (raw * (longint'(1) <<< FracBits)) / div;
  endfunction

  // product with floor shift, kept to 32 bits
  function automatic bit [31:0] fx_mul(bit [31:0] a, longint c);
    longint p;
    longint r;
    p = longint'(signed'(a)) * c;
    r = p >>> FracBits;
    return r[31:0];
  endfunction

  function automatic longint sine_at(int ph);
    int     k;
    bit     neg;
    longint v;
    k   = (ph * 200) / SinePoints;
    neg = 1'b0;
    if (k >= 200) k = 199;
    if (k > 100) begin
      neg = 1'b1;
      k   = k - 100;
    end
    if (k > 50) k = 100 - k;
    v = to_fixed(QWave[k], SineDiv);
    return neg ? -v : v;
  endfunction

  function automatic bit [31:0] filter_step(int s, bit [31:0] x);
    bit [31:0] acc;
    acc = '0;
    for (int i = NumB[s] - 1; i > 0; i--) x_hist[s][i] = x_hist[s][i-1];
    x_hist[s][0] = x;
    for (int i = 0; i < NumB[s]; i++)
      acc += fx_mul(x_hist[s][i], to_fixed(CoefB[s][i], CoefDiv));
    for (int i = 0; i < NumA[s]; i++)
      acc += fx_mul(y_hist[s][i], to_fixed(CoefA[s][i], CoefDiv));
    for (int i = NumA[s] - 1; i > 0; i--) y_hist[s][i] = y_hist[s][i-1];
    y_hist[s][0] = acc;
    return acc;
  endfunction

  function automatic bit [21:0] compute_duty(bit [31:0] vo, bit [31:0] il, bit [31:0] amp);
    bit [31:0] vref;
    bit [31:0] vf;
    bit [31:0] cf;
    bit [31:0] vc;
    bit [31:0] ic;
    longint    d;
    longint    lim;
    if (sine_on) vref = fx_mul(amp, sine_at(phase));
    else         vref = fx_mul(amp, longint'(1) <<< FracBits);
    if (duty_was_neg) il = 32'd0 - il;
    vf = filter_step(StVoltLpf, vo);
    cf = filter_step(StCurrLpf, il);
    vc = filter_step(StVoltCtl, vref - vf);
    ic = filter_step(StCurrCtl, vc - cf);
    d   = longint'(signed'(ic));
    lim = longint'(limit);
    if (d < -lim) d = -lim;
    if (d > lim)  d = lim;
    duty_was_neg = (d < 0);
    return d[21:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit [21:0] want;
    if (!rst_ni) begin
      foreach (x_hist[s, i]) x_hist[s][i] = '0;
      foreach (y_hist[s, i]) y_hist[s][i] = '0;
      phase        = '0;
      duty_was_neg = 1'b0;
      limit        = LimitW'(LimitReset);
      sine_on      = 1'b1;
      duty_q.delete();
      fail_cnt     = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegDutyLimit) limit = cfg_data_i;
        else                           sine_on = cfg_data_i[0];
      end
      if (s_valid_i && s_ready_i) begin
        if (s_user_i == ReqTick) begin
          phase = phase + 8'd1;
          if (phase >= SinePoints) phase = '0;
        end else begin
          duty_q.push_back(compute_duty(s_data_i[31:0], s_data_i[63:32], s_data_i[95:64]));
        end
      end
      if (m_valid_i && m_ready_i) begin
        if (duty_q.size() == 0) begin
          if (fail_cnt < 10) $display("unexpected duty word %0d", $signed(m_data_i[21:0]));
          fail_cnt++;
        end else begin
          want = duty_q.pop_front();
          if (m_data_i[21:0] !== want) begin
            if (fail_cnt < 10)
              $display("duty mismatch: expected %0d, got %0d",
                       $signed(want), $signed(m_data_i[21:0]));
            fail_cnt++;
          end
        end
      end
    end
    fail_cnt_o <= fail_cnt;
    pending_o  <= duty_q.size();
  end

endmodule

// ===== test/tb_cascaded_iir_duty_controller_unit.sv =====
// Testbench top for the cascaded IIR duty controller: drives samples, ticks
// and register writes with random idling and gives the verdict.
// Depends on cidc_pkg, cidc_tb_pkg and cidc_checker.
module tb_cascaded_iir_duty_controller_unit;
  import cidc_pkg::*;
  import cidc_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int NumPhases   = 6;
  localparam int RandPerPhase = 320;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [95:0]       s_axis_tdata;
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [23:0]       m_axis_tdata;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [LimitW-1:0] cfg_data_i;

  int fail_cnt;
  int pending;
  int cycles;
  bit quiet;

  cascaded_iir_duty_controller_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  cidc_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_i  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_user_i   (s_axis_tuser),
    .m_valid_i  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_i   (m_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: stall a random number of cycles before taking each word
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_word(input bit req, input bit [31:0] vo, input bit [31:0] il,
                           input bit [31:0] amp);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {amp, il, vo};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the sender until every duty word is back and the block has settled
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    // let the count of the word accepted at this edge reach pending
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [LimitW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic bit [31:0] rand_value();
    case ($urandom_range(0, 19))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2:    return $urandom();
      3, 4, 5: return 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
      default: return 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
    endcase
  endfunction

  initial begin
    bit [LimitW-1:0] lim;
    bit              mode;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ReqSample;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= RegDutyLimit;
    cfg_data_i    <= '0;
    quiet = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1:       begin lim = 21'd1048576;                       mode = 1'b0; end
          2:       begin lim = '0;                                mode = 1'b1; end
          3:       begin lim = LimitW'($urandom_range(1, 1048575)); mode = 1'b1; end
          4:       begin lim = 21'd1;                             mode = 1'b0; end
          default: begin lim = LimitW'($urandom_range(1000, 200000)); mode = 1'b0; end
        endcase
        write_reg(RegDutyLimit, lim);
        write_reg(RegSineMode, LimitW'(mode));
      end else begin
        // field extremes, current negation wrap, clamping both ways, ticks
        send_word(ReqSample, 32'h0, 32'h0, 32'h0);
        send_word(ReqSample, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_word(ReqSample, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(ReqSample, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001);
        send_word(ReqSample, 32'h0010_0000, 32'hfff0_0000, 32'h0010_0000);
        send_word(ReqTick, 32'h0, 32'h0, 32'h0);
        send_word(ReqSample, 32'h0, 32'h0010_0000, 32'h0640_0000);
        send_word(ReqSample, 32'hf9c0_0000, 32'h0, 32'hf9c0_0000);
        send_word(ReqTick, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_word(ReqTick, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f);
        send_word(ReqSample, 32'h0050_0000, 32'h0020_0000, 32'h00a0_0000);
        send_word(ReqSample, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        send_word(ReqSample, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
      end

      for (int n = 0; n < RandPerPhase; n++) begin
        quiet = (n < 50);
        if (ph == 2 && n == 160) wait_drained();
        // ticks about three in ten so the sine phase wraps several times
        send_word(($urandom_range(0, 9) < 3) ? ReqTick : ReqSample,
                  rand_value(), rand_value(), rand_value());
      end
    end

    quiet = 1'b0;
    wait_drained();
    if (fail_cnt == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
